/* sv/kpdc_pkg.sv */
package kpdc_pkg;

  localparam int unsigned PIN_W   = 4;   // edge_mask, pin_levels, held_mask
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SHORT = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_LONG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_TICKS  = 2'd2;

  localparam logic             RST_RELEASE_LEVEL = 1'b1;
  localparam logic [THR_W-1:0] RST_LONG_TICKS    = 16'd1000;
  localparam logic [THR_W-1:0] RST_BOUNCE_TICKS  = 16'd20;

  typedef struct packed {
    logic edge_en;   // pin of this key changed
    logic pressed;   // level differs from release level
    logic tick;
    logic clear;     // class cleared (read of this key or clear-all)
  } lane_cmd_t;

  typedef struct packed {
    logic               held_next;
    logic [CLASS_W-1:0] cls;
  } lane_stat_t;

  typedef struct packed {
    logic [CLASS_W-1:0] key_class;
    logic [PIN_W-1:0]   held_mask;
  } result_t;

endpackage

/* sv/kpdc_lane.sv */
module kpdc_lane #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kpdc_pkg::lane_cmd_t       cmd_i,
  input  logic [kpdc_pkg::THR_W-1:0] long_ticks_i,
  input  logic [kpdc_pkg::THR_W-1:0] bounce_ticks_i,
  output kpdc_pkg::lane_stat_t      stat_o
);
  import kpdc_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  logic                   held_q, held_d;
  logic                   pend_q, pend_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic [CLASS_W-1:0]     class_q, class_d;
  logic [CmpW-1:0]        ticks_ext;

  assign ticks_ext = CmpW'(ticks_q);

  always_comb begin
    held_d  = held_q;
    pend_d  = pend_q;
    ticks_d = ticks_q;
    class_d = class_q;
    if (cmd_i.edge_en) begin
      if (cmd_i.pressed) begin
        held_d  = 1'b1;
        pend_d  = 1'b0;
        ticks_d = '0;
      end else begin
        held_d = 1'b0;
        pend_d = 1'b1;
      end
    end
    if (cmd_i.tick) begin
      if (held_q) begin
        // saturate rather than wrap
        if (ticks_q != '1) begin
          ticks_d = ticks_q + COUNT_WIDTH'(1);
        end
      end else if (pend_q) begin
        pend_d  = 1'b0;
        ticks_d = '0;
        if (ticks_ext >= CmpW'(long_ticks_i)) begin
          class_d = CLASS_LONG;
        end else if (ticks_ext >= CmpW'(bounce_ticks_i)) begin
          class_d = CLASS_SHORT;
        end
      end
    end
    if (cmd_i.clear) begin
      class_d = CLASS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      pend_q  <= 1'b0;
      ticks_q <= '0;
      class_q <= CLASS_NONE;
    end else begin
      held_q  <= held_d;
      pend_q  <= pend_d;
      ticks_q <= ticks_d;
      class_q <= class_d;
    end
  end

  // class is reported as it stood before this transfer, held flag as after
  assign stat_o.held_next = held_d;
  assign stat_o.cls       = class_q;

endmodule

/* sv/kpdc_merge.sv */
module kpdc_merge #(
  parameter int unsigned KEY_COUNT = 4
) (
  input  kpdc_pkg::lane_stat_t       stat_i [KEY_COUNT],
  input  logic                       read_en_i,
  input  logic [kpdc_pkg::SEL_W-1:0] key_select_i,
  output kpdc_pkg::result_t          res_o
);
  import kpdc_pkg::*;

  // only the first keys have pins and a selectable index
  localparam int unsigned Lanes = (KEY_COUNT < PIN_W) ? KEY_COUNT : PIN_W;

  always_comb begin
    res_o.key_class = CLASS_NONE;
    res_o.held_mask = '0;
    for (int i = 0; i < Lanes; i++) begin
      res_o.held_mask[i] = stat_i[i].held_next;
      if (read_en_i && (key_select_i == SEL_W'(i))) begin
        res_o.key_class = stat_i[i].cls;
      end
    end
  end

endmodule

/* sv/kpdc_outbuf.sv */
module kpdc_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kpdc_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output kpdc_pkg::result_t data_o
);
  import kpdc_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_valid_q && !stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_valid_q && !pop) begin
      // receiver stalled: park the new result in the skid slot
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_d       = data_i;
      end
    end else if (skid_valid_q) begin
      main_valid_d = 1'b1;
      main_d       = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      main_valid_d = push_i;
      main_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

/* sv/key_press_duration_classifier_core.sv */
// Key press duration classifier, one lane per key.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// edge event, millisecond tick, read-and-clear of one key, or clear-all.
// Every accepted command yields exactly one result (key_class_o, held_mask_o)
// on the output channel (out_valid_o / out_stall_i), in order.
// The merged result is registered in the output buffer, not passed through combinationally.
// Throughput: one command per cycle while in_stall_o is low; all lanes update
// in the transfer cycle and the output buffer registers the merged result.
// The output has a two-entry buffer: while the receiver stalls one more
// command is still accepted into the skid slot, after which in_stall_o rises
// until the receiver takes a result.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; index 0 release
// level, 1 long-press threshold, 2 bounce threshold, others ignored.
// Reset clears all key state and buffers and loads release level 1,
// long threshold 1000 and bounce threshold 20 ticks.
module key_press_duration_classifier_core #(
  parameter int unsigned KEY_COUNT   = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [kpdc_pkg::PIN_W-1:0]     edge_mask_i,
  input  logic [kpdc_pkg::PIN_W-1:0]     pin_levels_i,
  input  logic [kpdc_pkg::SEL_W-1:0]     key_select_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kpdc_pkg::CLASS_W-1:0]   key_class_o,
  output logic [kpdc_pkg::PIN_W-1:0]     held_mask_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kpdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kpdc_pkg::THR_W-1:0]     cfg_data_i
);
  import kpdc_pkg::*;

  logic             release_level_q;
  logic [THR_W-1:0] long_ticks_q;
  logic [THR_W-1:0] bounce_ticks_q;

  logic  accept;
  logic  is_edge, is_tick, is_read, is_clear;
  mode_e mode;

  lane_cmd_t  cmd  [KEY_COUNT];
  lane_stat_t stat [KEY_COUNT];
  result_t    merged, result;
  logic       buf_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_level_q <= RST_RELEASE_LEVEL;
      long_ticks_q    <= RST_LONG_TICKS;
      bounce_ticks_q  <= RST_BOUNCE_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_RELEASE_LEVEL) begin
        release_level_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CFG_LONG_TICKS) begin
        long_ticks_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_BOUNCE_TICKS) begin
        bounce_ticks_q <= cfg_data_i;
      end
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign mode   = mode_e'(mode_i);

  always_comb begin
    is_edge  = 1'b0;
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    unique case (mode)
      MODE_EDGE:  is_edge  = accept;
      MODE_TICK:  is_tick  = accept;
      MODE_READ:  is_read  = accept;
      MODE_CLEAR: is_clear = accept;
      default:    is_edge  = 1'b0;
    endcase
  end

  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
    if (i < PIN_W) begin : g_pin
      assign cmd[i].edge_en = is_edge && edge_mask_i[i];
      assign cmd[i].pressed = pin_levels_i[i] != release_level_q;
      assign cmd[i].clear   = is_clear || (is_read && (key_select_i == SEL_W'(i)));
    end else begin : g_nopin
      // keys past the pin field never see edges or reads
      assign cmd[i].edge_en = 1'b0;
      assign cmd[i].pressed = 1'b0;
      assign cmd[i].clear   = is_clear;
    end
    assign cmd[i].tick = is_tick;

    kpdc_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd[i]),
      .long_ticks_i  (long_ticks_q),
      .bounce_ticks_i(bounce_ticks_q),
      .stat_o        (stat[i])
    );
  end

  kpdc_merge #(
    .KEY_COUNT(KEY_COUNT)
  ) u_merge (
    .stat_i      (stat),
    .read_en_i   (is_read),
    .key_select_i(key_select_i),
    .res_o       (merged)
  );

  kpdc_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (merged),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (result)
  );

  assign in_stall_o  = buf_full;
  assign key_class_o = result.key_class;
  assign held_mask_o = result.held_mask;

endmodule

/* sv/kpdc_checker.sv */
module kpdc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [kpdc_pkg::CLASS_W-1:0] key_class_o,
  input logic [kpdc_pkg::PIN_W-1:0]   held_mask_o
);
  import kpdc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_class_o)
      && $stable(held_mask_o))
    else $error("result changed while stalled");

  // every transfer in leaves out_valid_o high on the next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted command gave no result");

  // input back-pressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // no encoding beyond long
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_class_o <= CLASS_LONG)
    else $error("illegal key class");

endmodule

bind key_press_duration_classifier_core kpdc_checker u_kpdc_checker (.*);
